// ----- sv/relay_channel_safety_timer_top_assert.svh -----
// assertion macros for the relay channel safety timer checker
`ifndef RELAY_CHANNEL_SAFETY_TIMER_TOP_ASSERT_SVH
`define RELAY_CHANNEL_SAFETY_TIMER_TOP_ASSERT_SVH

// checked only while out of reset
`define RCST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RCST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rcst_pkg.sv -----
// ---------------------------------------------------------------------------
// rcst_pkg
// types and constants shared by the relay channel safety timer
// ---------------------------------------------------------------------------
package rcst_pkg;

    localparam int MASK_W      = 20;
    localparam int MS_W        = 16;
    localparam int ON_TIME_W   = 17;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    localparam logic [ON_TIME_W-1:0] ON_TIME_MAX = '1;

    localparam logic [MS_W-1:0]  ON_LIMIT_RESET = 16'd6000;
    localparam logic [MS_W-1:0]  PAUSE_RESET    = 16'd2500;
    localparam logic [CNT_W-1:0] COUNT_RESET    = '0;

    localparam logic [CFG_IDX_W-1:0] REG_ON_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [MS_W-1:0] tick_ms;
        logic            network_ok;
        logic            killed;
        logic [MS_W-1:0] on_limit_ms;
        logic [MS_W-1:0] pause_ms;
    } t_item_ctl;

    typedef struct packed {
        logic                 active;
        logic                 relay;
        logic [ON_TIME_W-1:0] on_time;
        logic [MS_W-1:0]      pause_left;
    } t_chan_state;

    typedef struct packed {
        logic started;
        logic halted;
    } t_chan_flags;

endpackage

// ----- sv/relay_channel_safety_timer_top.sv -----
// ---------------------------------------------------------------------------
// relay_channel_safety_timer_top
// relay channel safety timer: start/stop hit masked, tick all in-use channels
// ---------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser op, tdata mask/tick/flags
//  m_axis    out  m_axis_tvalid/tready       tdata relay/active/paused/led
//  cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  one beat per cycle sustained while the result is not stalled; a taken beat
//  goes through the input register, then the channel update into the result
//  register, before its result is offered
//  all channels update in parallel, no memory and no clear pass
//  synchronous active-low reset clears channel state and both registers
//  a stalled result holds the update stage; input keeps flowing while free
// ---------------------------------------------------------------------------
module relay_channel_safety_timer_top #(
    parameter int CHANNELS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rcst_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rcst_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // channel_mask[19:0], tick_ms[35:20], network_ok[36], local_trip[37],
    // remote_trip[38], zero[39]
    input  logic [rcst_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // op[1:0]
    input  logic [rcst_pkg::OP_W-1:0]             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // relay_on_mask[19:0], active_mask[39:20], paused_mask[59:40],
    // status_led[60], zero[63:61]
    output logic [rcst_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int MW = rcst_pkg::MASK_W;

    logic [rcst_pkg::MS_W-1:0]  r_on_limit;
    logic [rcst_pkg::MS_W-1:0]  r_pause_ms;
    logic [rcst_pkg::CNT_W-1:0] r_chan_count;

    logic                       r_in_valid;
    rcst_pkg::t_op              r_op;
    logic [MW-1:0]              r_mask;
    logic [rcst_pkg::MS_W-1:0]  r_tick;
    logic                       r_net_ok;
    logic                       r_killed;

    logic                                r_out_valid;
    logic [rcst_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic                                r_led;
    logic                                n_led;

    logic                   w_adv;
    rcst_pkg::t_item_ctl    w_ctl;
    rcst_pkg::t_chan_state  w_next  [CHANNELS];
    rcst_pkg::t_chan_flags  w_flags [CHANNELS];
    logic [CHANNELS-1:0]    w_started;
    logic [CHANNELS-1:0]    w_halted;
    logic [MW-1:0]          w_relay;
    logic [MW-1:0]          w_active;
    logic [MW-1:0]          w_paused;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_limit   <= rcst_pkg::ON_LIMIT_RESET;
            r_pause_ms   <= rcst_pkg::PAUSE_RESET;
            r_chan_count <= rcst_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcst_pkg::REG_ON_LIMIT: r_on_limit   <= i_cfg_data;
                rcst_pkg::REG_PAUSE:    r_pause_ms   <= i_cfg_data;
                rcst_pkg::REG_COUNT:    r_chan_count <= i_cfg_data[rcst_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= rcst_pkg::t_op'(s_axis_tuser);
            r_mask   <= s_axis_tdata[MW-1:0];
            r_tick   <= s_axis_tdata[MW +: rcst_pkg::MS_W];
            r_net_ok <= s_axis_tdata[MW + rcst_pkg::MS_W];
            r_killed <= s_axis_tdata[MW + rcst_pkg::MS_W + 1] |
                        s_axis_tdata[MW + rcst_pkg::MS_W + 2];
        end
    end

    always_comb begin
        w_ctl.op          = r_op;
        w_ctl.tick_ms     = r_tick;
        w_ctl.network_ok  = r_net_ok;
        w_ctl.killed      = r_killed;
        w_ctl.on_limit_ms = r_on_limit;
        w_ctl.pause_ms    = r_pause_ms;
    end

    // channel cells
    for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_chan
        logic w_sel;
        logic w_in_use;

        if (gi < MW) begin : g_sel
            assign w_sel = r_mask[gi];
        end else begin : g_nosel
            assign w_sel = 1'b0;
        end

        assign w_in_use = 6'(gi) < {1'b0, r_chan_count};

        rcst_chan u_chan (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_ctl    (w_ctl),
            .i_sel    (w_sel),
            .i_in_use (w_in_use),
            .o_next   (w_next[gi]),
            .o_flags  (w_flags[gi])
        );

        assign w_started[gi] = w_flags[gi].started;
        assign w_halted[gi]  = w_flags[gi].halted;
    end

    // reported channels
    for (genvar gi = 0; gi < MW; gi++) begin : g_out
        if (gi < CHANNELS) begin : g_real
            assign w_relay[gi]  = w_next[gi].relay;
            assign w_active[gi] = w_next[gi].active;
            assign w_paused[gi] = w_next[gi].pause_left != '0;
        end else begin : g_none
            assign w_relay[gi]  = 1'b0;
            assign w_active[gi] = 1'b0;
            assign w_paused[gi] = 1'b0;
        end
    end

    always_comb begin
        n_led = r_led;
        if (r_op == rcst_pkg::OP_START && |w_started) begin
            n_led = 1'b1;
        end else if (|w_halted) begin
            n_led = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_led       <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_led       <= n_led;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {{(rcst_pkg::OUT_TDATA_W - 3 * MW - 1){1'b0}},
                           n_led, w_paused, w_active, w_relay};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- sv/rcst_chan.sv -----
// ---------------------------------------------------------------------------
// rcst_chan
// one relay channel: state registers and the per-beat update
// ---------------------------------------------------------------------------
module rcst_chan (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  rcst_pkg::t_item_ctl    i_ctl,
    input  logic                   i_sel,
    input  logic                   i_in_use,
    output rcst_pkg::t_chan_state  o_next,
    output rcst_pkg::t_chan_flags  o_flags
);

    rcst_pkg::t_chan_state r_state;
    rcst_pkg::t_chan_state n_state;
    rcst_pkg::t_chan_flags n_flags;

    logic [rcst_pkg::MS_W-1:0]      w_pause_tick;
    logic [rcst_pkg::ON_TIME_W-1:0] w_on_tick;
    logic [rcst_pkg::ON_TIME_W:0]   w_on_sum;

    // aged counters for a tick
    always_comb begin
        w_on_sum     = {1'b0, r_state.on_time} + (rcst_pkg::ON_TIME_W + 1)'(i_ctl.tick_ms);
        w_pause_tick = r_state.pause_left;
        w_on_tick    = r_state.on_time;
        if (r_state.pause_left != '0) begin
            w_pause_tick = (r_state.pause_left > i_ctl.tick_ms) ?
                           (r_state.pause_left - i_ctl.tick_ms) : '0;
        end else if (r_state.active) begin
            w_on_tick = w_on_sum[rcst_pkg::ON_TIME_W] ? rcst_pkg::ON_TIME_MAX :
                        w_on_sum[rcst_pkg::ON_TIME_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_flags = '0;
        if (i_in_use) begin
            case (i_ctl.op)
                rcst_pkg::OP_START: begin
                    if (i_sel && r_state.pause_left == '0 && !r_state.active &&
                        r_state.on_time <= {1'b0, i_ctl.on_limit_ms}) begin
                        n_state.active  = 1'b1;
                        n_state.on_time = '0;
                        if (!i_ctl.killed) begin
                            n_state.relay = 1'b1;
                        end
                        n_flags.started = 1'b1;
                    end
                end
                rcst_pkg::OP_STOP: begin
                    if (i_sel && r_state.active) begin
                        n_state.active  = 1'b0;
                        n_state.relay   = 1'b0;
                        n_state.on_time = '0;
                        n_flags.halted  = 1'b1;
                    end
                end
                rcst_pkg::OP_TICK: begin
                    n_state.pause_left = w_pause_tick;
                    n_state.on_time    = w_on_tick;
                    if (r_state.active && !i_ctl.network_ok) begin
                        n_state.active  = 1'b0;
                        n_state.relay   = 1'b0;
                        n_state.on_time = '0;
                        n_flags.halted  = 1'b1;
                    end else if (w_on_tick > {1'b0, i_ctl.on_limit_ms}) begin
                        n_state.pause_left = i_ctl.pause_ms;
                        if (r_state.active) begin
                            n_state.active  = 1'b0;
                            n_state.relay   = 1'b0;
                            n_state.on_time = '0;
                            n_flags.halted  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    assign o_next  = n_state;
    assign o_flags = n_flags;

endmodule

// ----- sv/rcst_checker.sv -----
// ---------------------------------------------------------------------------
// rcst_checker
// port-level checks on the relay channel safety timer
// ---------------------------------------------------------------------------
`include "relay_channel_safety_timer_top_assert.svh"

module rcst_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [rcst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int MW = rcst_pkg::MASK_W;

    logic [MW-1:0] w_relay;
    logic [MW-1:0] w_active;
    logic [MW-1:0] w_paused;

    assign w_relay  = m_axis_tdata[MW-1:0];
    assign w_active = m_axis_tdata[2*MW-1:MW];
    assign w_paused = m_axis_tdata[3*MW-1:2*MW];

    `RCST_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")

    `RCST_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

    `RCST_ASSERT(a_relay_active, i_clk, i_rst_n, m_axis_tvalid |-> (w_relay & ~w_active) == '0, "relay driven on inactive channel")

    `RCST_ASSERT(a_active_paused, i_clk, i_rst_n, m_axis_tvalid |-> (w_active & w_paused) == '0, "channel active while paused")

    `RCST_ASSERT(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind relay_channel_safety_timer_top rcst_checker u_rcst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the relay channel safety timer: directed and random
// start, stop and tick beats are predicted channel by channel and every
// result beat is compared field by field, under bursty input, patterned
// output stalls and a range of limit, pause and channel count settings
// ---------------------------------------------------------------------------
module tb_top;

    localparam int NCH            = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 8;
    localparam int PHASE_BEATS    = 120;

    localparam int MW  = rcst_pkg::MASK_W;
    localparam int TW  = rcst_pkg::MS_W;
    localparam int OW  = rcst_pkg::OP_W;
    localparam int IW  = rcst_pkg::CFG_IDX_W;
    localparam int DW  = rcst_pkg::CFG_DATA_W;

    localparam logic [OW-1:0] OP_IDLE  = 2'd3;
    localparam logic [MW-1:0] ALL_CHAN = '1;

    typedef struct {
        logic [OW-1:0] op;
        logic [MW-1:0] mask;
        logic [TW-1:0] tick_ms;
        logic          net_ok;
        logic          local_trip;
        logic          remote_trip;
    } t_beat;

    typedef struct {
        logic [MW-1:0] relay;
        logic [MW-1:0] active;
        logic [MW-1:0] paused;
        logic          led;
    } t_status;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_cfg_we = 1'b0;
    logic [IW-1:0]                          i_cfg_idx = '0;
    logic [DW-1:0]                          i_cfg_data = '0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [rcst_pkg::IN_TDATA_W-1:0]        s_axis_tdata = '0;
    logic [OW-1:0]                          s_axis_tuser = '0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [rcst_pkg::OUT_TDATA_W-1:0]       m_axis_tdata;

    relay_channel_safety_timer_top #(
        .CHANNELS(NCH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // predicted channel state and register copies
    logic [TW-1:0]                  lim_ms = rcst_pkg::ON_LIMIT_RESET;
    logic [TW-1:0]                  pause_cfg = rcst_pkg::PAUSE_RESET;
    logic [rcst_pkg::CNT_W-1:0]     chan_cnt = rcst_pkg::COUNT_RESET;
    logic                           ch_active [NCH] = '{default: 1'b0};
    logic                           ch_relay [NCH] = '{default: 1'b0};
    logic [rcst_pkg::ON_TIME_W-1:0] ch_on_ms [NCH] = '{default: '0};
    logic [TW-1:0]                  ch_pause [NCH] = '{default: '0};
    logic                           led_on = 1'b0;

    int errors = 0;
    int beats_in = 0;
    int results_out = 0;
    int reg_writes = 0;
    int op_seen [4] = '{default: 0};
    int limit_halts = 0;
    int net_halts = 0;

    function automatic logic halt_channel(int i);
        if (!ch_active[i])
            return 1'b0;
        ch_active[i] = 1'b0;
        ch_relay[i]  = 1'b0;
        ch_on_ms[i]  = '0;
        return 1'b1;
    endfunction

    function automatic t_status relay_timer_apply(t_beat b);
        int n;
        logic killed;
        logic changed;
        logic [rcst_pkg::ON_TIME_W:0] sum;
        t_status r;
        n = (chan_cnt < NCH) ? int'(chan_cnt) : NCH;
        killed = b.local_trip | b.remote_trip;
        changed = 1'b0;
        op_seen[b.op]++;
        case (b.op)
            rcst_pkg::OP_START: begin
                for (int i = 0; i < n; i++) begin
                    if (b.mask[i] && ch_pause[i] == 0 && !ch_active[i] &&
                        ch_on_ms[i] <= lim_ms) begin
                        ch_active[i] = 1'b1;
                        ch_on_ms[i]  = '0;
                        if (!killed)
                            ch_relay[i] = 1'b1;
                        changed = 1'b1;
                    end
                end
                if (changed)
                    led_on = 1'b1;
            end
            rcst_pkg::OP_STOP: begin
                for (int i = 0; i < n; i++) begin
                    if (b.mask[i] && halt_channel(i))
                        changed = 1'b1;
                end
                if (changed)
                    led_on = 1'b0;
            end
            rcst_pkg::OP_TICK: begin
                for (int i = 0; i < n; i++) begin
                    if (ch_pause[i] > 0) begin
                        ch_pause[i] = (ch_pause[i] > b.tick_ms) ?
                                      ch_pause[i] - b.tick_ms : '0;
                    end else if (ch_active[i]) begin
                        sum = {1'b0, ch_on_ms[i]} + b.tick_ms;
                        ch_on_ms[i] = (sum > rcst_pkg::ON_TIME_MAX) ?
                                      rcst_pkg::ON_TIME_MAX :
                                      sum[rcst_pkg::ON_TIME_W-1:0];
                    end
                    if (ch_active[i] && !b.net_ok) begin
                        if (halt_channel(i)) begin
                            changed = 1'b1;
                            net_halts++;
                        end
                    end else if (ch_on_ms[i] > lim_ms) begin
                        ch_pause[i] = pause_cfg;
                        if (halt_channel(i)) begin
                            changed = 1'b1;
                            limit_halts++;
                        end
                    end
                end
                if (changed)
                    led_on = 1'b0;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < NCH; i++) begin
            r.relay[i]  = ch_relay[i];
            r.active[i] = ch_active[i];
            r.paused[i] = (ch_pause[i] != 0);
        end
        r.led = led_on;
        return r;
    endfunction

    function automatic void check_field(string name, logic [MW-1:0] want,
                                        logic [MW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // sender: bursts of beats separated by random gaps
    t_beat pending_beats [$];
    logic  in_taken = 1'b0;
    int    burst_left = 0;
    int    gap_left = 0;
    logic  steady_send = 1'b0;

    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
    end

    always @(negedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (burst_left == 0) begin
                steady_send = ($urandom_range(0, 5) == 0);
                burst_left  = $urandom_range(1, steady_send ? 200 : 24);
                gap_left    = steady_send ? 0 : $urandom_range(0, 10);
            end
            if (gap_left > 0 || pending_beats.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_axis_tvalid <= 1'b0;
            end else begin
                b = pending_beats.pop_front();
                s_axis_tdata  <= {1'b0, b.remote_trip, b.local_trip, b.net_ok,
                                  b.tick_ms, b.mask};
                s_axis_tuser  <= b.op;
                s_axis_tvalid <= 1'b1;
                burst_left--;
            end
        end
    end

    // receiver: rotating stall pattern, plus a long hold on request
    logic [15:0] rx_pattern = 16'hFFFF;
    int rx_pattern_age = 0;
    int rx_hold_cnt = 0;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;

    always @(negedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen = rx_hold_req;
            rx_hold_cnt  = LONG_HOLD;
        end
        if (rx_pattern_age == 0) begin
            rx_pattern_age = $urandom_range(64, 512);
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                         16'($urandom_range(1, 16'hFFFF));
        end
        rx_pattern_age--;
        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rx_pattern[0];
        end
    end

    // prediction on input beats, comparison on result beats
    t_status expected_status_q [$];

    always @(posedge i_clk) begin
        t_beat b;
        t_status got;
        t_status want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                b.op          = s_axis_tuser;
                b.mask        = s_axis_tdata[19:0];
                b.tick_ms     = s_axis_tdata[35:20];
                b.net_ok      = s_axis_tdata[36];
                b.local_trip  = s_axis_tdata[37];
                b.remote_trip = s_axis_tdata[38];
                expected_status_q.push_back(relay_timer_apply(b));
                beats_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_out++;
                got.relay  = m_axis_tdata[19:0];
                got.active = m_axis_tdata[39:20];
                got.paused = m_axis_tdata[59:40];
                got.led    = m_axis_tdata[60];
                if (expected_status_q.size() == 0) begin
                    $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("relay_on_mask", want.relay, got.relay);
                    check_field("active_mask", want.active, got.active);
                    check_field("paused_mask", want.paused, got.paused);
                    check_field("status_led", MW'(want.led), MW'(got.led));
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_status_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rcst_pkg::REG_ON_LIMIT: lim_ms = val;
            rcst_pkg::REG_PAUSE:    pause_cfg = val;
            rcst_pkg::REG_COUNT:    chan_cnt = val[rcst_pkg::CNT_W-1:0];
            default: begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_beat(logic [OW-1:0] op, logic [MW-1:0] mask,
                                     logic [TW-1:0] tick_ms, logic net_ok,
                                     logic local_trip, logic remote_trip);
        t_beat b;
        b.op          = op;
        b.mask        = mask;
        b.tick_ms     = tick_ms;
        b.net_ok      = net_ok;
        b.local_trip  = local_trip;
        b.remote_trip = remote_trip;
        pending_beats.push_back(b);
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            b.op = rcst_pkg::OP_START;
        else if (pick < 48)
            b.op = rcst_pkg::OP_STOP;
        else if (pick < 96)
            b.op = rcst_pkg::OP_TICK;
        else
            b.op = OP_IDLE;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            b.mask = ALL_CHAN;
        else if (pick == 1)
            b.mask = '0;
        else if (pick == 2)
            b.mask = MW'(1) << $urandom_range(0, MW - 1);
        else
            b.mask = MW'($urandom_range(0, 20'hFFFFF));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            b.tick_ms = TW'($urandom_range(0, 16'hFFFF));
        else if (pick == 1)
            b.tick_ms = '0;
        else
            b.tick_ms = TW'($urandom_range(0, lim_ms / 6 + 1));
        b.net_ok      = ($urandom_range(0, 19) != 0);
        b.local_trip  = ($urandom_range(0, 7) == 0);
        b.remote_trip = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    initial begin
        int unsigned ph_limit [PHASES];
        int unsigned ph_pause [PHASES];
        int unsigned ph_count [PHASES];
        ph_limit = '{6000, 0, 65535, 400, 1000, 0, 2500, 0};
        ph_pause = '{2500, 0, 65535, 0, 65535, 500, 1200, 0};
        ph_count = '{20, 20, 20, 7, 1, 0, 31, 0};
        ph_limit[PHASES-1] = $urandom_range(0, 20000);
        ph_pause[PHASES-1] = $urandom_range(0, 5000);
        ph_count[PHASES-1] = $urandom_range(0, 20);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no channel in use
        add_beat(rcst_pkg::OP_START, ALL_CHAN, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_TICK, ALL_CHAN, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        wait_drained();
        write_reg(rcst_pkg::REG_COUNT, DW'(NCH));

        add_beat(rcst_pkg::OP_START, ALL_CHAN, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_STOP, 20'h00001, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_TICK, '0, 16'd1000, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_TICK, '0, 16'hFFFF, 1'b1, 1'b0, 1'b0);   // limit hit, pause
        add_beat(rcst_pkg::OP_START, ALL_CHAN, '0, 1'b1, 1'b0, 1'b0);  // blocked by pause but for channel 0
        add_beat(rcst_pkg::OP_TICK, '0, 16'd2000, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_TICK, '0, 16'hFFFF, 1'b1, 1'b0, 1'b0);   // pause floors at zero
        add_beat(rcst_pkg::OP_START, 20'hAAAAA, '0, 1'b1, 1'b1, 1'b0);
        add_beat(rcst_pkg::OP_START, 20'h55555, '0, 1'b1, 1'b0, 1'b1);
        add_beat(rcst_pkg::OP_START, ALL_CHAN, '0, 1'b1, 1'b1, 1'b1);
        add_beat(rcst_pkg::OP_TICK, ALL_CHAN, 16'd5, 1'b0, 1'b0, 1'b0); // network down
        add_beat(rcst_pkg::OP_START, ALL_CHAN, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        add_beat(OP_IDLE, ALL_CHAN, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        add_beat(rcst_pkg::OP_STOP, 20'hF0F0F, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_TICK, '0, 16'd6000, 1'b1, 1'b0, 1'b0);   // exactly at limit
        add_beat(rcst_pkg::OP_TICK, '0, 16'd1, 1'b1, 1'b0, 1'b0);      // one past limit
        add_beat(rcst_pkg::OP_START, '0, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_STOP, '0, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_START, 20'h80000, '0, 1'b1, 1'b1, 1'b1); // active but dark
        add_beat(rcst_pkg::OP_TICK, '0, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_STOP, 20'h80000, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_START, 20'h80000, '0, 1'b1, 1'b0, 1'b0);
        add_beat(rcst_pkg::OP_START, ALL_CHAN, '0, 1'b1, 1'b1, 1'b0);  // kill keeps driven relay
        add_beat(rcst_pkg::OP_STOP, ALL_CHAN, '0, 1'b1, 1'b0, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(rcst_pkg::REG_ON_LIMIT, DW'(ph_limit[p]));
            write_reg(rcst_pkg::REG_PAUSE, DW'(ph_pause[p]));
            write_reg(rcst_pkg::REG_COUNT, DW'(ph_count[p]));
            if (p == 0)
                rx_hold_req++;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                pending_beats.push_back(random_beat());
                // in phase 2 only, the sender waits for every result once mid-phase
                if (p == 2 && k == PHASE_BEATS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        $display("tb: %0d beats in, %0d results out, %0d register writes",
                 beats_in, results_out, reg_writes);
        $display("tb: %0d starts, %0d stops, %0d ticks, %0d idle ops; %0d limit and %0d %s",
                 op_seen[rcst_pkg::OP_START], op_seen[rcst_pkg::OP_STOP],
                 op_seen[rcst_pkg::OP_TICK], op_seen[OP_IDLE],
                 limit_halts, net_halts, "network stops");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- relay_channel_safety_timer_top.f -----
+incdir+sv
sv/rcst_pkg.sv
sv/rcst_chan.sv
sv/relay_channel_safety_timer_top.sv
sv/rcst_checker.sv
test/tb_top.sv
